>>> design/tcw_pkg.sv
// Shared constants, command types and helpers for the text console writer.
package tcw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);

	localparam int OPC_W   = 2;
	localparam int CHAR_W  = 8;
	localparam int IDX_W   = 11;
	localparam int COLOR_W = 8;
	localparam int CELL_W  = 16;
	localparam int ROW_W   = 5;
	localparam int COL_W   = 7;

	localparam logic [OPC_W-1:0] OP_PUT   = 2'd0;
	localparam logic [OPC_W-1:0] OP_READ  = 2'd1;
	localparam logic [OPC_W-1:0] OP_CLEAR = 2'd2;

	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
	localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;

	localparam int TAB_SPACES = 4;
	localparam int REM_W      = $clog2(TAB_SPACES);

	localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h0A;
	localparam logic [CELL_W-1:0]  RESET_BLANK = {COLOR_RESET, BLANK_CHAR};

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		CMD_PRINT,
		CMD_TAB,
		CMD_NEWLINE,
		CMD_RETURN,
		CMD_BACKSPACE,
		CMD_READ,
		CMD_CLEAR,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [CHAR_W-1:0]  ch;
		logic [IDX_W-1:0]   cell_index;
		logic               in_range;
	} cmd_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		cell_addr = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
	endfunction

endpackage

>>> design/tcw_if.sv
// Handshake channel interfaces: request, response and color write.
interface tcw_req_if;
	logic                        valid;
	logic                        ready;
	logic [tcw_pkg::OPC_W-1:0]   opcode;
	logic [tcw_pkg::CHAR_W-1:0]  char_code;
	logic [tcw_pkg::IDX_W-1:0]   cell_index;

	modport source (output valid, opcode, char_code, cell_index, input ready);
	modport sink (input valid, opcode, char_code, cell_index, output ready);
endinterface

interface tcw_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [tcw_pkg::CELL_W-1:0]  cell_data;
	logic [tcw_pkg::ROW_W-1:0]   cursor_row;
	logic [tcw_pkg::COL_W-1:0]   cursor_col;

	modport source (output valid, cell_data, cursor_row, cursor_col, input ready);
	modport sink (input valid, cell_data, cursor_row, cursor_col, output ready);
endinterface

interface tcw_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [tcw_pkg::COLOR_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

>>> design/tcw_front.sv
// Front end: accepts requests and classifies them into console commands.
module tcw_front (
	input  logic          init_busy,
	tcw_req_if.sink       req,
	output logic          push_valid,
	input  logic          push_ready,
	output tcw_pkg::cmd_t push_cmd
);
	import tcw_pkg::*;

	cmd_kind_t kind;

	always_comb begin
		case (req.opcode)
			OP_PUT: begin
				case (req.char_code)
					CH_BACKSPACE: kind = CMD_BACKSPACE;
					CH_TAB:       kind = CMD_TAB;
					CH_NEWLINE:   kind = CMD_NEWLINE;
					CH_RETURN:    kind = CMD_RETURN;
					default:      kind = CMD_PRINT;
				endcase
			end
			OP_READ:  kind = CMD_READ;
			OP_CLEAR: kind = CMD_CLEAR;
			default:  kind = CMD_NOP;
		endcase
	end

	assign push_cmd.kind       = kind;
	assign push_cmd.ch         = req.char_code;
	assign push_cmd.cell_index = req.cell_index;
	assign push_cmd.in_range   = int'(req.cell_index) < CELL_COUNT;

	// no requests during the power-up clearing pass
	assign push_valid = req.valid && !init_busy;
	assign req.ready  = push_ready && !init_busy;

endmodule

>>> design/tcw_cmd_fifo.sv
// Short command queue between the front end and the back end.
module tcw_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  tcw_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop_ready,
	output tcw_pkg::cmd_t pop_cmd
);
	import tcw_pkg::*;

	cmd_t               entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = count_q != QCNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> design/tcw_back.sv
// Back end: screen memory, cursor, scroll and clear sequencer, response register.
module tcw_back (
	input  logic          clk,
	input  logic          arst_n,
	tcw_cfg_if.sink       cfg,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  tcw_pkg::cmd_t cmd,
	output logic          init_busy,
	tcw_rsp_if.source     rsp
);
	import tcw_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PUT,
		S_READ,
		S_SCROLL,
		S_FILL
	} state_t;

	state_t              state_q;
	logic                init_q;
	logic [ADDR_W-1:0]   cnt_q;
	logic [CELL_W-1:0]   fill_val_q;
	logic [ROW_W-1:0]    row_q;
	logic [COL_W-1:0]    col_q;
	logic [REM_W-1:0]    rem_q;
	logic [COLOR_W-1:0]  color_q;
	logic [CHAR_W-1:0]   put_ch_q;
	logic                rd_ok_q;
	logic                rsp_valid_q;
	logic [CELL_W-1:0]   rsp_data_q;
	logic [ROW_W-1:0]    rsp_row_q;
	logic [COL_W-1:0]    rsp_col_q;

	logic [CELL_W-1:0]   mem_q [CELL_COUNT];
	logic [CELL_W-1:0]   rd_data_q;
	logic [ADDR_W-1:0]   rd_addr;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [CELL_W-1:0]   mem_wdata;

	logic                out_free;
	logic                cmd_pop;
	logic                at_last_col;
	logic                at_last_row;
	logic                at_origin;
	logic [ROW_W-1:0]    bs_row;
	logic [COL_W-1:0]    bs_col;
	logic [ROW_W-1:0]    put_row;
	logic [COL_W-1:0]    put_col;
	logic [CELL_W-1:0]   blank;

	assign out_free    = !rsp_valid_q || rsp.ready;
	assign cmd_pop     = (state_q == S_IDLE) && cmd_valid && out_free;
	assign cmd_ready   = cmd_pop;
	assign init_busy   = init_q;
	assign cfg.ready   = 1'b1;

	assign at_last_col = col_q == COL_W'(COLUMNS - 1);
	assign at_last_row = row_q == ROW_W'(ROWS - 2);
	assign at_origin   = (row_q == '0) && (col_q == '0);
	assign bs_row      = (col_q == '0) ? row_q - 1'b1 : row_q;
	assign bs_col      = (col_q == '0) ? COL_W'(COLUMNS - 1) : col_q - 1'b1;
	assign put_row     = at_last_col ? row_q + 1'b1 : row_q;
	assign put_col     = at_last_col ? '0 : col_q + 1'b1;
	assign blank       = {color_q, BLANK_CHAR};

	// scroll reads one row ahead of the cell being written
	assign rd_addr = (state_q == S_SCROLL) ? cnt_q + ADDR_W'(COLUMNS)
		: ADDR_W'(cmd.cell_index);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q;
		mem_wdata = fill_val_q;
		case (state_q)
			S_FILL: begin
				mem_we = 1'b1;
			end
			S_SCROLL: begin
				mem_we    = cnt_q != '0;
				mem_waddr = cnt_q - 1'b1;
				mem_wdata = rd_data_q;
			end
			S_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = cell_addr(row_q, col_q);
				mem_wdata = {color_q, put_ch_q};
			end
			S_IDLE: begin
				mem_we    = cmd_pop && (cmd.kind == CMD_BACKSPACE) && !at_origin;
				mem_waddr = cell_addr(bs_row, bs_col);
				mem_wdata = blank;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_FILL;
			init_q      <= 1'b1;
			cnt_q       <= '0;
			fill_val_q  <= RESET_BLANK;
			row_q       <= '0;
			col_q       <= '0;
			rem_q       <= '0;
			color_q     <= COLOR_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				color_q <= cfg.data;
			end
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_pop) begin
						case (cmd.kind)
							CMD_PRINT: begin
								put_ch_q <= cmd.ch;
								rem_q    <= '0;
								state_q  <= S_PUT;
							end
							CMD_TAB: begin
								put_ch_q <= BLANK_CHAR;
								rem_q    <= REM_W'(TAB_SPACES - 1);
								state_q  <= S_PUT;
							end
							CMD_NEWLINE: begin
								col_q <= '0;
								if (at_last_row) begin
									rem_q   <= '0;
									cnt_q   <= '0;
									state_q <= S_SCROLL;
								end else begin
									row_q       <= row_q + 1'b1;
									rsp_valid_q <= 1'b1;
									rsp_data_q  <= '0;
									rsp_row_q   <= row_q + 1'b1;
									rsp_col_q   <= '0;
								end
							end
							CMD_RETURN: begin
								col_q       <= '0;
								rsp_valid_q <= 1'b1;
								rsp_data_q  <= '0;
								rsp_row_q   <= row_q;
								rsp_col_q   <= '0;
							end
							CMD_BACKSPACE: begin
								rsp_valid_q <= 1'b1;
								rsp_data_q  <= '0;
								if (at_origin) begin
									rsp_row_q <= row_q;
									rsp_col_q <= col_q;
								end else begin
									row_q     <= bs_row;
									col_q     <= bs_col;
									rsp_row_q <= bs_row;
									rsp_col_q <= bs_col;
								end
							end
							CMD_READ: begin
								rd_ok_q <= cmd.in_range;
								state_q <= S_READ;
							end
							CMD_CLEAR: begin
								row_q      <= '0;
								col_q      <= '0;
								rem_q      <= '0;
								cnt_q      <= '0;
								fill_val_q <= blank;
								state_q    <= S_FILL;
							end
							default: begin
								rsp_valid_q <= 1'b1;
								rsp_data_q  <= '0;
								rsp_row_q   <= row_q;
								rsp_col_q   <= col_q;
							end
						endcase
					end
				end
				S_PUT: begin
					col_q <= put_col;
					if (at_last_col && at_last_row) begin
						cnt_q   <= '0;
						state_q <= S_SCROLL;
					end else begin
						row_q <= put_row;
						if (rem_q != '0) begin
							rem_q <= rem_q - 1'b1;
						end else begin
							rsp_valid_q <= 1'b1;
							rsp_data_q  <= '0;
							rsp_row_q   <= put_row;
							rsp_col_q   <= put_col;
							state_q     <= S_IDLE;
						end
					end
				end
				S_READ: begin
					rsp_valid_q <= 1'b1;
					rsp_data_q  <= rd_ok_q ? rd_data_q : '0;
					rsp_row_q   <= row_q;
					rsp_col_q   <= col_q;
					state_q     <= S_IDLE;
				end
				S_SCROLL: begin
					// cursor already sits on the last text row at column 0
					if (cnt_q == ADDR_W'(CELL_COUNT - COLUMNS)) begin
						fill_val_q <= blank;
						state_q    <= S_FILL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_FILL: begin
					if (cnt_q == ADDR_W'(CELL_COUNT - 1)) begin
						if (init_q) begin
							init_q  <= 1'b0;
							state_q <= S_IDLE;
						end else if (rem_q != '0) begin
							rem_q   <= rem_q - 1'b1;
							state_q <= S_PUT;
						end else begin
							rsp_valid_q <= 1'b1;
							rsp_data_q  <= '0;
							rsp_row_q   <= row_q;
							rsp_col_q   <= col_q;
							state_q     <= S_IDLE;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.cell_data  = rsp_data_q;
	assign rsp.cursor_row = rsp_row_q;
	assign rsp.cursor_col = rsp_col_q;

endmodule

>>> design/text_console_character_writer.sv
// Top level of the text console character writer.
// 80x25 text console with a 2000-cell screen memory and a cursor over rows 0..23. Each
// request gives exactly one response carrying the cursor after the operation and, for a
// read, the cell (0 beyond the screen). A command queue of two entries sits between the
// request decoder and the executing back end, and a response register lets a new request
// enter while a response waits. A tab prints four blanks; a scroll copies the rows up
// by one and then blanks the last row, and a clear blanks every cell. After reset the
// memory is blanked in a pass during which no request is accepted; the color register
// can be written at any time the block is idle.
module text_console_character_writer (
	input  logic      clk,
	input  logic      arst_n,
	tcw_cfg_if.sink   cfg,
	tcw_req_if.sink   req,
	tcw_rsp_if.source rsp
);
	import tcw_pkg::*;

	logic  init_busy;
	logic  push_valid;
	logic  push_ready;
	cmd_t  push_cmd;
	logic  pop_valid;
	logic  pop_ready;
	cmd_t  pop_cmd;

	tcw_front u_front (
		.init_busy  (init_busy),
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	tcw_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	tcw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd_valid  (pop_valid),
		.cmd_ready  (pop_ready),
		.cmd        (pop_cmd),
		.init_busy  (init_busy),
		.rsp        (rsp)
	);

endmodule

>>> design/tcw_checker.sv
// Port-level checks for the text console writer, bound to the top level.
module tcw_port_assertions (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [tcw_pkg::CELL_W-1:0] rsp_cell_data,
	input logic [tcw_pkg::ROW_W-1:0]  rsp_cursor_row,
	input logic [tcw_pkg::COL_W-1:0]  rsp_cursor_col
);
	import tcw_pkg::*;

	logic [2:0] outstanding_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			outstanding_q <= outstanding_q + 3'(req_valid && req_ready)
				- 3'(rsp_valid && rsp_ready);
		end
	end

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_cursor_row <= ROW_W'(ROWS - 2))
		else $error("cursor row beyond last text row");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_cursor_col <= COL_W'(COLUMNS - 1))
		else $error("cursor column beyond last column");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid
			&& $stable({rsp_cell_data, rsp_cursor_row, rsp_cursor_col}))
		else $error("stalled response changed");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> outstanding_q != '0)
		else $error("response without an outstanding request");

endmodule

bind text_console_character_writer tcw_port_assertions u_tcw_port_assertions (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_cell_data  (rsp.cell_data),
	.rsp_cursor_row (rsp.cursor_row),
	.rsp_cursor_col (rsp.cursor_col)
);

>>> verif/tcw_checker.sv
// Checker for the text console writer: mirrors the screen and cursor, compares every response.
`timescale 1ns / 1ps
module tcw_checker (
	input  logic clk,
	input  logic arst_n,
	tcw_cfg_if   cfg,
	tcw_req_if   req,
	tcw_rsp_if   rsp,
	output int   fail_count,
	output int   pending
);
	import tcw_pkg::*;

	typedef struct packed {
		logic [CELL_W-1:0] cell_data;
		logic [ROW_W-1:0]  cursor_row;
		logic [COL_W-1:0]  cursor_col;
	} console_reply_t;

	logic [CELL_W-1:0]  screen [CELL_COUNT];
	logic [COLOR_W-1:0] color;
	int                 cur_row;
	int                 cur_col;
	console_reply_t     replies_due [$];

	function automatic logic [CELL_W-1:0] blank_word();
		return {color, BLANK_CHAR};
	endfunction

	function automatic void blank_screen();
		for (int i = 0; i < CELL_COUNT; i++)
			screen[i] = blank_word();
	endfunction

	function automatic void shift_screen_up();
		for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
			screen[i] = screen[i + COLUMNS];
		for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
			screen[i] = blank_word();
		cur_row = ROWS - 2;
		cur_col = 0;
	endfunction

	function automatic void write_glyph(input logic [CHAR_W-1:0] ch);
		int pos;
		pos = cur_row * COLUMNS + cur_col;
		if (pos < CELL_COUNT)
			screen[pos] = {color, ch};
		cur_col++;
		if (cur_col >= COLUMNS) begin
			cur_col = 0;
			cur_row++;
			if (cur_row >= ROWS - 1)
				shift_screen_up();
		end
	endfunction

	function automatic void apply_char(input logic [CHAR_W-1:0] ch);
		int pos;
		case (ch)
			CH_NEWLINE: begin
				if (cur_row + 1 >= ROWS - 1) begin
					shift_screen_up();
				end else begin
					cur_row++;
					cur_col = 0;
				end
			end
			CH_RETURN: begin
				cur_col = 0;
			end
			CH_TAB: begin
				for (int k = 0; k < TAB_SPACES; k++)
					write_glyph(BLANK_CHAR);
			end
			CH_BACKSPACE: begin
				if (cur_row != 0 || cur_col != 0) begin
					if (cur_col == 0) begin
						cur_row--;
						cur_col = COLUMNS - 1;
					end else begin
						cur_col--;
					end
					pos = cur_row * COLUMNS + cur_col;
					if (pos < CELL_COUNT)
						screen[pos] = blank_word();
				end
			end
			default: begin
				write_glyph(ch);
			end
		endcase
	endfunction

	function automatic console_reply_t run_console_op(input logic [OPC_W-1:0] op,
			input logic [CHAR_W-1:0] ch, input logic [IDX_W-1:0] idx);
		console_reply_t r;
		r.cell_data = '0;
		case (op)
			OP_PUT: begin
				apply_char(ch);
			end
			OP_READ: begin
				if (int'(idx) < CELL_COUNT)
					r.cell_data = screen[idx];
			end
			OP_CLEAR: begin
				blank_screen();
				cur_row = 0;
				cur_col = 0;
			end
			default: begin
			end
		endcase
		r.cursor_row = ROW_W'(cur_row);
		r.cursor_col = COL_W'(cur_col);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		console_reply_t want;
		console_reply_t got;
		if (!arst_n) begin
			color = COLOR_RESET;
			blank_screen();
			cur_row = 0;
			cur_col = 0;
			replies_due.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				got.cell_data  = rsp.cell_data;
				got.cursor_row = rsp.cursor_row;
				got.cursor_col = rsp.cursor_col;
				if (replies_due.size() == 0) begin
					$error("response with no request outstanding: cell_data %h row %0d col %0d",
						got.cell_data, got.cursor_row, got.cursor_col);
					fail_count++;
				end else begin
					want = replies_due.pop_front();
					if (got.cell_data !== want.cell_data) begin
						$error("cell_data mismatch: expected %h, actual %h",
							want.cell_data, got.cell_data);
						fail_count++;
					end
					if (got.cursor_row !== want.cursor_row) begin
						$error("cursor_row mismatch: expected %0d, actual %0d",
							want.cursor_row, got.cursor_row);
						fail_count++;
					end
					if (got.cursor_col !== want.cursor_col) begin
						$error("cursor_col mismatch: expected %0d, actual %0d",
							want.cursor_col, got.cursor_col);
						fail_count++;
					end
				end
			end
			if (cfg.valid && cfg.ready)
				color = cfg.data;
			if (req.valid && req.ready)
				replies_due.push_back(run_console_op(req.opcode, req.char_code, req.cell_index));
		end
		pending = replies_due.size();
	end

endmodule

>>> verif/tb.sv
// Testbench top: clock, reset, request and color stimulus, receiver stalls and the verdict.
`timescale 1ns / 1ps
module tb;
	import tcw_pkg::*;

	localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 2100;
	localparam int HOLD_CYCLES   = 400;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 132;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   send_pct = 0;
	int   recv_pct = 0;
	int   newline_pct = 12;
	bit   holding = 1'b0;
	event hold_go;

	tcw_req_if req ();
	tcw_rsp_if rsp ();
	tcw_cfg_if cfg ();

	text_console_character_writer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.rsp    (rsp)
	);

	tcw_checker console_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.req        (req),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp.ready <= !holding && ($urandom_range(0, 99) >= recv_pct);
		end
	end

	initial begin
		forever begin
			@(hold_go);
			@(posedge clk);
			holding = 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			holding = 1'b0;
		end
	end

	task automatic send_item(input logic [OPC_W-1:0] op, input logic [CHAR_W-1:0] ch,
			input logic [IDX_W-1:0] idx);
		while ($urandom_range(0, 99) < send_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid      <= 1'b1;
		req.opcode     <= op;
		req.char_code  <= ch;
		req.cell_index <= idx;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random();
		int                pick;
		logic [OPC_W-1:0]  op;
		logic [CHAR_W-1:0] ch;
		logic [IDX_W-1:0]  idx;
		pick = $urandom_range(0, 99);
		ch   = CHAR_W'($urandom_range(0, 255));
		idx  = IDX_W'($urandom_range(0, 2047));
		if (pick == 0 && $urandom_range(0, 3) == 0) begin
			op = OP_CLEAR;
		end else if (pick < 3) begin
			op = OP_UNUSED;
		end else if (pick < 25) begin
			op = OP_READ;
			if ($urandom_range(0, 3) == 0)
				idx = IDX_W'($urandom_range(CELL_COUNT - 3 * COLUMNS, 2047));
			else
				idx = IDX_W'($urandom_range(0, CELL_COUNT - 1));
		end else begin
			op   = OP_PUT;
			pick = $urandom_range(0, 99);
			if (pick < newline_pct)
				ch = CH_NEWLINE;
			else if (pick < newline_pct + 2)
				ch = CH_RETURN;
			else if (pick < newline_pct + 7)
				ch = CH_TAB;
			else if (pick < newline_pct + 13)
				ch = CH_BACKSPACE;
		end
		send_item(op, ch, idx);
	endtask

	task automatic write_color(input logic [COLOR_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.data  <= value;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// waits until no response is outstanding, then lets the bench settle before the next phase
	task automatic drain();
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		logic [COLOR_W-1:0] phase_color [PHASES];
		req.valid      = 1'b0;
		req.opcode     = OP_PUT;
		req.char_code  = '0;
		req.cell_index = '0;
		cfg.valid      = 1'b0;
		cfg.data       = '0;
		arst_n         = 1'b0;
		phase_color = '{8'h00, 8'hFF, COLOR_W'($urandom_range(0, 255)), 8'h0F,
			COLOR_W'($urandom_range(0, 255)), 8'hF0, COLOR_W'($urandom_range(0, 255)), 8'hA5};
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		send_item(OP_READ, 8'h00, 11'd0);
		send_item(OP_PUT, CH_BACKSPACE, 11'd0);
		send_item(OP_PUT, 8'h41, 11'd0);
		send_item(OP_PUT, 8'hFF, 11'd0);
		send_item(OP_PUT, 8'h00, 11'd0);
		send_item(OP_PUT, CH_TAB, 11'd0);
		send_item(OP_PUT, CH_BACKSPACE, 11'd0);
		send_item(OP_READ, 8'h00, 11'd1);
		send_item(OP_PUT, CH_RETURN, 11'd0);
		send_item(OP_PUT, 8'h7E, 11'd0);
		send_item(OP_PUT, CH_NEWLINE, 11'd0);
		send_item(OP_PUT, CH_BACKSPACE, 11'd0);
		send_item(OP_READ, 8'h00, 11'd79);
		send_item(OP_READ, 8'h00, 11'd1999);
		send_item(OP_READ, 8'h00, 11'd2000);
		send_item(OP_READ, 8'hFF, 11'h7FF);
		send_item(OP_UNUSED, 8'hFF, 11'h7FF);
		send_item(OP_CLEAR, 8'h00, 11'd0);
		send_item(OP_READ, 8'h00, 11'd0);
		send_item(OP_READ, 8'h00, 11'd1);
		req.valid <= 1'b0;
		drain();

		for (int p = 0; p < PHASES; p++) begin
			write_color(phase_color[p]);
			case (p % 4)
				0: begin send_pct = 0;  recv_pct = 0;  end
				1: begin send_pct = 56; recv_pct = 0;  end
				2: begin send_pct = 0;  recv_pct = 56; end
				default: begin send_pct = 13; recv_pct = 13; end
			endcase
			newline_pct = ((p / 2) % 2 == 0) ? 12 : 1;
			if (p == 0)
				-> hold_go;
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_random();
			req.valid <= 1'b0;
			drain();
		end

		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> files.f
design/tcw_pkg.sv
design/tcw_if.sv
design/tcw_front.sv
design/tcw_cmd_fifo.sv
design/tcw_back.sv
design/text_console_character_writer.sv
design/tcw_checker.sv
verif/tcw_checker.sv
verif/tb.sv
